// File: rtl/kfi_pkg.sv
// Shared types and codes for the keyframe interpolation block.
// Used by kfi_lane, the top level and the port checker.
package kfi_pkg;

  localparam int unsigned MaxKeysDef    = 64;
  localparam int unsigned StateDimDef   = 4;
  localparam int unsigned ControlDimDef = 4;
  localparam int unsigned MaxDim        = 4;
  localparam int unsigned FracW         = 16;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  // spare code: no table change, status ok
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DECR  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        time_point;
    logic signed [31:0] state_in_0;
    logic signed [31:0] state_in_1;
    logic signed [31:0] state_in_2;
    logic signed [31:0] state_in_3;
    logic signed [31:0] control_in_0;
    logic signed [31:0] control_in_1;
    logic signed [31:0] control_in_2;
    logic signed [31:0] control_in_3;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] state_out_0;
    logic signed [31:0] state_out_1;
    logic signed [31:0] state_out_2;
    logic signed [31:0] state_out_3;
    logic signed [31:0] control_out_0;
    logic signed [31:0] control_out_1;
    logic signed [31:0] control_out_2;
    logic signed [31:0] control_out_3;
    logic [6:0]         key_count;
  } out_t;

  // Per-lane strobes from the sequencer.
  typedef struct packed {
    logic ld0;   // capture earlier keyframe element
    logic ld1;   // capture later keyframe element
    logic mul;   // register (s1 - s0) * f
  } lane_ctl_t;

endpackage

// File: rtl/kfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kfi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/kfi_div.sv
// Bit-serial restoring divider for the Q0.16 interpolation fraction.
// Computes floor((num << 16) / den) for num < den. No package use.
module kfi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [15:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shl;
  logic [32:0] sub;

  assign shl = {rem_q, 1'b0};
  assign sub = shl - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      quo_d  = '0;
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit a cycle
      if (shl >= {1'b0, den_q}) begin
        rem_d = sub[31:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = shl[31:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/kfi_lane.sv
// One interpolation lane: s0 + floor((s1 - s0) * f / 2^16) for one state element.
// Depends on kfi_pkg for the lane strobe struct.
module kfi_lane (
  input  logic                   clk_i,
  input  kfi_pkg::lane_ctl_t     ctl_i,
  input  logic signed [31:0]     rdata_i,
  input  logic [15:0]            frac_i,
  output logic signed [31:0]     res_o
);

  logic signed [31:0] s0_q;
  logic signed [31:0] s1_q;
  logic signed [49:0] prod_q;
  logic signed [32:0] delta;
  logic signed [49:0] prod_d;
  logic signed [49:0] shr;

  assign delta  = {s1_q[31], s1_q} - {s0_q[31], s0_q};
  assign prod_d = 50'(delta * $signed({1'b0, frac_i}));

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld0) begin
      s0_q <= rdata_i;
    end
    if (ctl_i.ld1) begin
      s1_q <= rdata_i;
    end
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  // arithmetic shift gives the floor for negative products too
  assign shr   = prod_q >>> 16;
  assign res_o = s0_q + shr[31:0];

endmodule

// File: rtl/keyframe_interp_with_control_hold.sv
// Keyframe table with linear state interpolation and held control. A query outside
// the stored span returns an end keyframe. A query inside the span runs an upper-bound
// search on the single read port of the time memory (ceil(log2(count+1)) probes, 7 at
// 64 keys), then a keyframe fetch, the bit-serial fraction divider and the lane
// multiply and output. One item is in work at a time; the output register lets the
// next item be accepted while a result waits. Memories are not cleared; only entries
// below the count are read.
module keyframe_interp_with_control_hold #(
  parameter int unsigned MAX_KEYS    = kfi_pkg::MaxKeysDef,
  parameter int unsigned STATE_DIM   = kfi_pkg::StateDimDef,
  parameter int unsigned CONTROL_DIM = kfi_pkg::ControlDimDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kfi_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kfi_pkg::out_t out_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PROBE_RD  = 4'd1;
  localparam logic [3:0] S_PROBE_CMP = 4'd2;
  localparam logic [3:0] S_FETCH0    = 4'd3;
  localparam logic [3:0] S_FETCH1    = 4'd4;
  localparam logic [3:0] S_FETCH2    = 4'd5;
  localparam logic [3:0] S_DIV       = 4'd6;
  localparam logic [3:0] S_MUL       = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [31:0]       first_q, first_d;
  logic [31:0]       last_q, last_d;
  logic [31:0]       t_q, t_d;
  logic [31:0]       t0_q, t0_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d, lo_n, hi_n, mid;
  logic [AW-1:0]     idx_q, idx_d;
  logic [15:0]       f_q, f_d;
  logic              emit_q, emit_d;
  logic              zero_q, zero_d;
  logic [1:0]        status_q, status_d;
  logic              out_valid_q, out_valid_d;
  kfi_pkg::out_t     out_q, out_d, res;

  logic              we;
  logic [AW-1:0]     raddr;
  logic [31:0]       time_rdata;
  kfi_pkg::lane_ctl_t lane_ctl;
  logic              div_start, div_done;
  logic [15:0]       div_quo;

  logic signed [31:0] st_in   [kfi_pkg::MaxDim];
  logic signed [31:0] ct_in   [kfi_pkg::MaxDim];
  logic signed [31:0] st_res  [kfi_pkg::MaxDim];
  logic signed [31:0] ct_res  [kfi_pkg::MaxDim];
  logic signed [31:0] st_mrg  [kfi_pkg::MaxDim];
  logic signed [31:0] ct_mrg  [kfi_pkg::MaxDim];

  assign st_in[0] = in_i.state_in_0;
  assign st_in[1] = in_i.state_in_1;
  assign st_in[2] = in_i.state_in_2;
  assign st_in[3] = in_i.state_in_3;
  assign ct_in[0] = in_i.control_in_0;
  assign ct_in[1] = in_i.control_in_1;
  assign ct_in[2] = in_i.control_in_2;
  assign ct_in[3] = in_i.control_in_3;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  kfi_ram #(.Width(32), .Depth(MAX_KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_i.time_point),
    .raddr_i (raddr),
    .rdata_o (time_rdata)
  );

  for (genvar i = 0; i < kfi_pkg::MaxDim; i++) begin : g_state
    if (i < STATE_DIM) begin : g_on
      logic [31:0] rdata;
      kfi_ram #(.Width(32), .Depth(MAX_KEYS)) u_ram (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (count_q[AW-1:0]),
        .wdata_i (st_in[i]),
        .raddr_i (raddr),
        .rdata_o (rdata)
      );
      kfi_lane u_lane (
        .clk_i   (clk_i),
        .ctl_i   (lane_ctl),
        .rdata_i ($signed(rdata)),
        .frac_i  (f_q),
        .res_o   (st_res[i])
      );
    end else begin : g_off
      assign st_res[i] = '0;
    end
  end

  for (genvar i = 0; i < kfi_pkg::MaxDim; i++) begin : g_ctrl
    if (i < CONTROL_DIM) begin : g_on
      logic [31:0]        rdata;
      logic signed [31:0] hold_q;
      kfi_ram #(.Width(32), .Depth(MAX_KEYS)) u_ram (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (count_q[AW-1:0]),
        .wdata_i (ct_in[i]),
        .raddr_i (raddr),
        .rdata_o (rdata)
      );
      // hold the control of the earlier keyframe
      always_ff @(posedge clk_i) begin
        if (lane_ctl.ld0) begin
          hold_q <= $signed(rdata);
        end
      end
      assign ct_res[i] = hold_q;
    end else begin : g_off
      assign ct_res[i] = '0;
    end
  end

  kfi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q - t0_q),
    .den_i   (time_rdata - t0_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // merge the lanes into one result beat
  always_comb begin
    for (int i = 0; i < kfi_pkg::MaxDim; i++) begin
      st_mrg[i] = zero_q ? 32'sd0 : st_res[i];
      ct_mrg[i] = zero_q ? 32'sd0 : ct_res[i];
    end
    res               = '0;
    res.status        = status_q;
    res.state_out_0   = st_mrg[0];
    res.state_out_1   = st_mrg[1];
    res.state_out_2   = st_mrg[2];
    res.state_out_3   = st_mrg[3];
    res.control_out_0 = ct_mrg[0];
    res.control_out_1 = ct_mrg[1];
    res.control_out_2 = ct_mrg[2];
    res.control_out_3 = ct_mrg[3];
    res.key_count     = 7'(count_q);
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    first_d     = first_q;
    last_d      = last_q;
    t_d         = t_q;
    t0_d        = t0_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lo_n        = lo_q;
    hi_n        = hi_q;
    idx_d       = idx_q;
    f_d         = f_q;
    emit_d      = emit_q;
    zero_d      = zero_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    raddr       = '0;
    lane_ctl    = '0;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d      = in_i.time_point;
          status_d = kfi_pkg::ST_OK;
          zero_d   = 1'b1;
          state_d  = S_DONE;
          case (in_i.mode)
            kfi_pkg::MODE_APPEND: begin
              if (count_q >= CW'(MAX_KEYS)) begin
                status_d = kfi_pkg::ST_FULL;
              end else if (count_q != '0 && in_i.time_point < last_q) begin
                status_d = kfi_pkg::ST_DECR;
              end else begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
                last_d  = in_i.time_point;
                if (count_q == '0) begin
                  first_d = in_i.time_point;
                end
              end
            end
            kfi_pkg::MODE_QUERY: begin
              if (count_q == '0) begin
                status_d = kfi_pkg::ST_EMPTY;
              end else begin
                zero_d = 1'b0;
                f_d    = '0;
                if (in_i.time_point <= first_q) begin
                  idx_d   = '0;
                  emit_d  = 1'b1;
                  state_d = S_FETCH0;
                end else if (in_i.time_point >= last_q) begin
                  idx_d   = AW'(count_q - 1'b1);
                  emit_d  = 1'b1;
                  state_d = S_FETCH0;
                end else begin
                  lo_d    = '0;
                  hi_d    = count_q;
                  emit_d  = 1'b0;
                  state_d = S_PROBE_RD;
                end
              end
            end
            kfi_pkg::MODE_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_PROBE_RD: begin
        raddr   = mid[AW-1:0];
        state_d = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        if (time_rdata > t_q) begin
          hi_n = mid;
        end else begin
          lo_n = mid + 1'b1;
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n == hi_n) begin
          idx_d   = AW'(lo_n - 1'b1);
          state_d = S_FETCH0;
        end else begin
          state_d = S_PROBE_RD;
        end
      end
      S_FETCH0: begin
        raddr   = idx_q;
        state_d = S_FETCH1;
      end
      S_FETCH1: begin
        // end keyframe: load both sides so the lane returns s0 unchanged
        lane_ctl.ld0 = 1'b1;
        lane_ctl.ld1 = emit_q;
        t0_d         = time_rdata;
        raddr        = idx_q + 1'b1;
        state_d      = emit_q ? S_MUL : S_FETCH2;
      end
      S_FETCH2: begin
        lane_ctl.ld1 = 1'b1;
        div_start    = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          f_d     = div_quo;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        lane_ctl.mul = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    last_q   <= last_d;
    t_q      <= t_d;
    t0_q     <= t0_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    idx_q    <= idx_d;
    f_q      <= f_d;
    emit_q   <= emit_d;
    zero_q   <= zero_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/kfi_checker.sv
// Port-level checks for keyframe_interp_with_control_hold, bound to the top level.
// Depends on kfi_pkg for status codes and default parameters.
module kfi_checker #(
  parameter int unsigned MAX_KEYS = kfi_pkg::MaxKeysDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input kfi_pkg::out_t out_o
);

  // one item in work at a time: drop ready after an accepted beat
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat dropped or changed while stalled");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == kfi_pkg::ST_EMPTY |-> out_o.key_count == 7'd0)
    else $error("empty-table status with nonzero key count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == kfi_pkg::ST_FULL |-> out_o.key_count == 7'(MAX_KEYS))
    else $error("table-full status with wrong key count");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == kfi_pkg::ST_DECR || out_o.status == kfi_pkg::ST_FULL)
    |-> out_o.state_out_0 == 32'sd0 && out_o.control_out_0 == 32'sd0)
    else $error("rejected append returned nonzero data");

endmodule

bind keyframe_interp_with_control_hold kfi_checker #(.MAX_KEYS(MAX_KEYS)) u_kfi_checker (.*);
